// ----- rtl/sclm_pkg.sv -----
// Shared types, codes and defaults for the sorted complex magnitude table.
package sclm_pkg;

   localparam int DEPTH_DEF         = 16;
   localparam int KEY_WIDTH_DEF     = 16;
   localparam int PAYLOAD_WIDTH_DEF = 32;

   localparam int MODE_W    = 3;
   localparam int STATUS_W  = 2;
   localparam int POS_W     = 4;
   localparam int OUT_IDX_W = 5;
   localparam int OUT_KEY_W = 16;
   localparam int OUT_PAY_W = 32;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 3'd0,
      MODE_SEARCH = 3'd1,
      MODE_LOCATE = 3'd2,
      MODE_READ   = 3'd3,
      MODE_DELETE = 3'd4
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_MISS = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SHIFT_HOLD = 2'd0,
      SHIFT_UP   = 2'd1,
      SHIFT_DOWN = 2'd2
   } shift_type;

   typedef enum logic [1:0] {
      FLAG_GE = 2'd0,
      FLAG_GT = 2'd1,
      FLAG_EQ = 2'd2
   } flag_type;

   typedef enum logic [1:0] {
      SRC_NONE = 2'd0,
      SRC_NEW  = 2'd1,
      SRC_CELL = 2'd2
   } source_type;

   typedef struct packed {
      flag_type  flag_sel;
      shift_type shift;
   } cell_ctrl_type;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_SQUARE  = 6'b000010,
      ST_COMPARE = 6'b000100,
      ST_FIND    = 6'b001000,
      ST_SELECT  = 6'b010000,
      ST_EXEC    = 6'b100000
   } state_type;

endpackage

// ----- rtl/sclm_if.sv -----
// Request and response channel interfaces of the sorted complex magnitude table.
interface sclm_req_if #(
   parameter int KEY_WIDTH     = sclm_pkg::KEY_WIDTH_DEF,
   parameter int PAYLOAD_WIDTH = sclm_pkg::PAYLOAD_WIDTH_DEF
);
   logic                              valid;
   logic                              ready;
   logic [sclm_pkg::MODE_W-1:0]       mode;
   logic signed [KEY_WIDTH-1:0]       key_real;
   logic signed [KEY_WIDTH-1:0]       key_imag;
   logic [PAYLOAD_WIDTH-1:0]          payload;
   logic [sclm_pkg::POS_W-1:0]        position;

   modport source (output valid, mode, key_real, key_imag, payload, position, input ready);
   modport sink   (input valid, mode, key_real, key_imag, payload, position, output ready);
endinterface

interface sclm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [sclm_pkg::STATUS_W-1:0]       status;
   logic [sclm_pkg::OUT_IDX_W-1:0]      out_index;
   logic signed [sclm_pkg::OUT_KEY_W-1:0] out_real;
   logic signed [sclm_pkg::OUT_KEY_W-1:0] out_imag;
   logic [sclm_pkg::OUT_PAY_W-1:0]      out_payload;
   logic                                hit;
   logic [sclm_pkg::OUT_IDX_W-1:0]      out_count;

   modport source (output valid, status, out_index, out_real, out_imag, out_payload, hit,
                   out_count, input ready);
   modport sink   (input valid, status, out_index, out_real, out_imag, out_payload, hit,
                   out_count, output ready);
endinterface

// ----- rtl/sorted_complex_magnitude_list.sv -----
// Sorted complex magnitude table: top level with sequencer, cell row and response register.
//
// Usage: one request word on req_chan carries a mode (insert, exact search, magnitude
// locate, read, delete), a signed complex key, a payload and a position. Every request
// gives exactly one response word on rsp_chan with status, index, the entry's key and
// payload, the locate hit bit and the entry count after the operation.
// Entries sit in a row of cells in ascending order of squared magnitude; each cell
// compares itself with the probe in parallel and shifts to its neighbour on insert
// or delete.
// Sequence: the square, compare, find-first, select and execute steps run in that order
// after the request word is accepted, and the response is registered at the end of the
// execute step; one request is in flight at a time.
// Stall: a finished response waits in the output register; a new request is taken
// meanwhile, and its execute step holds until the output register is free.
// Reset: synchronous, active high; clears the entry count and the control state.
// The table is empty after reset; no clearing pass is needed.
module sorted_complex_magnitude_list #(
   parameter int DEPTH         = sclm_pkg::DEPTH_DEF,
   parameter int KEY_WIDTH     = sclm_pkg::KEY_WIDTH_DEF,
   parameter int PAYLOAD_WIDTH = sclm_pkg::PAYLOAD_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   sclm_req_if.sink      req_chan,
   sclm_rsp_if.source    rsp_chan
);

   localparam int KW = KEY_WIDTH;
   localparam int PW = PAYLOAD_WIDTH;
   localparam int MW = 2 * KEY_WIDTH;
   localparam int EW = 4 * KEY_WIDTH + PAYLOAD_WIDTH;
   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int RW = (CW > sclm_pkg::POS_W) ? CW : sclm_pkg::POS_W;

   sclm_pkg::state_type   state_ff, state_in;
   sclm_pkg::mode_type    mode_ff;
   logic signed [KW-1:0]  key_re_ff, key_im_ff;
   logic [PW-1:0]         pay_ff;
   logic [sclm_pkg::POS_W-1:0] pos_ff;
   logic signed [MW-1:0]  re_sq_ff, im_sq_ff, re_sq_in, im_sq_in;
   logic [MW-1:0]         pm_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic                  found_ff, found_in;
   logic [IW-1:0]         first_ff, first_in;

   sclm_pkg::status_type  sel_status_ff, sel_status_in;
   logic [sclm_pkg::OUT_IDX_W-1:0] sel_index_ff, sel_index_in;
   logic [IW-1:0]         target_ff, target_in;
   logic                  sel_hit_ff, sel_hit_in;
   sclm_pkg::source_type  src_ff, src_in;
   sclm_pkg::shift_type   shift_ff, shift_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   sclm_pkg::status_type  rsp_status_ff;
   logic [sclm_pkg::OUT_IDX_W-1:0] rsp_index_ff, rsp_count_ff, rsp_count_in;
   logic [sclm_pkg::OUT_KEY_W-1:0] rsp_real_ff, rsp_imag_ff, rsp_real_in, rsp_imag_in;
   logic [sclm_pkg::OUT_PAY_W-1:0] rsp_pay_ff, rsp_pay_in;
   logic                  rsp_hit_ff;

   logic                  accept, exec_go;
   logic [EW-1:0]         new_entry, rd_entry;
   logic [EW-1:0]         cell_entry [DEPTH];
   logic [EW-1:0]         cell_left  [DEPTH];
   logic [EW-1:0]         cell_right [DEPTH];
   logic [DEPTH-1:0]      cell_flag;
   sclm_pkg::cell_ctrl_type cell_ctrl;

   logic [RW-1:0]         pos_w, cnt_w, c_w, lo_w;
   logic                  in_range, loc_hit, full;

   assign accept        = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == sclm_pkg::ST_IDLE) && !reset;
   assign exec_go       = (state_ff == sclm_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);

   // squares taken straight from the request word and registered on accept, summed in the square step
   assign re_sq_in = MW'(req_chan.key_real) * MW'(req_chan.key_real);
   assign im_sq_in = MW'(req_chan.key_imag) * MW'(req_chan.key_imag);

   assign new_entry = {pm_ff, key_re_ff, key_im_ff, pay_ff};

   always_comb begin
      case (mode_ff)
         sclm_pkg::MODE_SEARCH: cell_ctrl.flag_sel = sclm_pkg::FLAG_EQ;
         sclm_pkg::MODE_LOCATE: cell_ctrl.flag_sel = sclm_pkg::FLAG_GT;
         default:               cell_ctrl.flag_sel = sclm_pkg::FLAG_GE;
      endcase
      cell_ctrl.shift = exec_go ? shift_ff : sclm_pkg::SHIFT_HOLD;
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign cell_left[g] = new_entry;
      end else begin : g_body
         assign cell_left[g] = cell_entry[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
         assign cell_right[g] = cell_entry[g];
      end else begin : g_inner
         assign cell_right[g] = cell_entry[g+1];
      end

      sclm_cell #(
         .KEY_WIDTH     (KEY_WIDTH),
         .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
         .INDEX_WIDTH   (IW),
         .COUNT_WIDTH   (CW),
         .INDEX         (g)
      ) u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .target      (target_ff),
         .count       (count_ff),
         .new_entry   (new_entry),
         .left_entry  (cell_left[g]),
         .right_entry (cell_right[g]),
         .entry       (cell_entry[g]),
         .flag        (cell_flag[g])
      );
   end

   sclm_find_first #(
      .WIDTH       (DEPTH),
      .INDEX_WIDTH (IW)
   ) u_find_first (
      .flags (cell_flag),
      .found (found_in),
      .first (first_in)
   );

   // select: turn the first-flag position into index, status and cell command
   always_comb begin
      pos_w    = RW'(pos_ff);
      cnt_w    = RW'(count_ff);
      c_w      = found_ff ? RW'(first_ff) : cnt_w;
      in_range = pos_w < cnt_w;
      loc_hit  = c_w > pos_w;
      lo_w     = loc_hit ? c_w - RW'(1) : pos_w;
      full     = cnt_w == RW'(DEPTH);

      sel_status_in = sclm_pkg::STATUS_MISS;
      sel_index_in  = '0;
      target_in     = IW'(pos_w);
      sel_hit_in    = 1'b0;
      src_in        = sclm_pkg::SRC_NONE;
      shift_in      = sclm_pkg::SHIFT_HOLD;

      case (mode_ff)
         sclm_pkg::MODE_INSERT: begin
            if (full) begin
               sel_status_in = sclm_pkg::STATUS_FULL;
            end else begin
               sel_status_in = sclm_pkg::STATUS_DONE;
               sel_index_in  = sclm_pkg::OUT_IDX_W'(c_w);
               target_in     = IW'(c_w);
               src_in        = sclm_pkg::SRC_NEW;
               shift_in      = sclm_pkg::SHIFT_UP;
            end
         end
         sclm_pkg::MODE_SEARCH: begin
            target_in = first_ff;
            if (found_ff) begin
               sel_status_in = sclm_pkg::STATUS_DONE;
               sel_index_in  = sclm_pkg::OUT_IDX_W'(first_ff);
               src_in        = sclm_pkg::SRC_CELL;
            end
         end
         sclm_pkg::MODE_LOCATE: begin
            target_in = IW'(lo_w);
            if (in_range) begin
               sel_status_in = sclm_pkg::STATUS_DONE;
               sel_index_in  = sclm_pkg::OUT_IDX_W'(lo_w);
               sel_hit_in    = loc_hit;
               src_in        = sclm_pkg::SRC_CELL;
            end
         end
         sclm_pkg::MODE_READ: begin
            if (in_range) begin
               sel_status_in = sclm_pkg::STATUS_DONE;
               sel_index_in  = sclm_pkg::OUT_IDX_W'(pos_w);
               src_in        = sclm_pkg::SRC_CELL;
            end
         end
         sclm_pkg::MODE_DELETE: begin
            if (in_range) begin
               sel_status_in = sclm_pkg::STATUS_DONE;
               sel_index_in  = sclm_pkg::OUT_IDX_W'(pos_w);
               src_in        = sclm_pkg::SRC_CELL;
               shift_in      = sclm_pkg::SHIFT_DOWN;
            end
         end
         default: sel_status_in = sclm_pkg::STATUS_MISS;
      endcase
   end

   assign rd_entry = cell_entry[target_ff];

   always_comb begin
      case (src_ff)
         sclm_pkg::SRC_NEW: begin
            rsp_real_in = sclm_pkg::OUT_KEY_W'(new_entry[PW+2*KW-1:PW+KW]);
            rsp_imag_in = sclm_pkg::OUT_KEY_W'(new_entry[PW+KW-1:PW]);
            rsp_pay_in  = sclm_pkg::OUT_PAY_W'(new_entry[PW-1:0]);
         end
         sclm_pkg::SRC_CELL: begin
            rsp_real_in = sclm_pkg::OUT_KEY_W'(rd_entry[PW+2*KW-1:PW+KW]);
            rsp_imag_in = sclm_pkg::OUT_KEY_W'(rd_entry[PW+KW-1:PW]);
            rsp_pay_in  = sclm_pkg::OUT_PAY_W'(rd_entry[PW-1:0]);
         end
         default: begin
            rsp_real_in = '0;
            rsp_imag_in = '0;
            rsp_pay_in  = '0;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (exec_go) begin
         case (shift_ff)
            sclm_pkg::SHIFT_UP:   count_in = count_ff + CW'(1);
            sclm_pkg::SHIFT_DOWN: count_in = count_ff - CW'(1);
            default:              count_in = count_ff;
         endcase
      end
      rsp_count_in = sclm_pkg::OUT_IDX_W'(count_in);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sclm_pkg::ST_IDLE:    if (accept) state_in = sclm_pkg::ST_SQUARE;
         sclm_pkg::ST_SQUARE:  state_in = sclm_pkg::ST_COMPARE;
         sclm_pkg::ST_COMPARE: state_in = sclm_pkg::ST_FIND;
         sclm_pkg::ST_FIND:    state_in = sclm_pkg::ST_SELECT;
         sclm_pkg::ST_SELECT:  state_in = sclm_pkg::ST_EXEC;
         sclm_pkg::ST_EXEC:    if (exec_go) state_in = sclm_pkg::ST_IDLE;
         default:              state_in = sclm_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = exec_go || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sclm_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= sclm_pkg::mode_type'(req_chan.mode);
         key_re_ff <= req_chan.key_real;
         key_im_ff <= req_chan.key_imag;
         pay_ff    <= req_chan.payload;
         pos_ff    <= req_chan.position;
         re_sq_ff  <= re_sq_in;
         im_sq_ff  <= im_sq_in;
      end
      if (state_ff == sclm_pkg::ST_SQUARE) begin
         pm_ff <= MW'(unsigned'(re_sq_ff)) + MW'(unsigned'(im_sq_ff));
      end
      if (state_ff == sclm_pkg::ST_FIND) begin
         found_ff <= found_in;
         first_ff <= first_in;
      end
      if (state_ff == sclm_pkg::ST_SELECT) begin
         sel_status_ff <= sel_status_in;
         sel_index_ff  <= sel_index_in;
         target_ff     <= target_in;
         sel_hit_ff    <= sel_hit_in;
         src_ff        <= src_in;
         shift_ff      <= shift_in;
      end
      if (exec_go) begin
         rsp_status_ff <= sel_status_ff;
         rsp_index_ff  <= sel_index_ff;
         rsp_real_ff   <= rsp_real_in;
         rsp_imag_ff   <= rsp_imag_in;
         rsp_pay_ff    <= rsp_pay_in;
         rsp_hit_ff    <= sel_hit_ff;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.out_index   = rsp_index_ff;
   assign rsp_chan.out_real    = rsp_real_ff;
   assign rsp_chan.out_imag    = rsp_imag_ff;
   assign rsp_chan.out_payload = rsp_pay_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.out_count   = rsp_count_ff;

   a_state_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above table depth");

   a_full_hold : assert property (@(posedge clock) disable iff (reset)
      (exec_go && sel_status_ff == sclm_pkg::STATUS_FULL) |=> $stable(count_ff))
      else $error("rejected insert changed the entry count");

   a_delete_count : assert property (@(posedge clock) disable iff (reset)
      (exec_go && shift_ff == sclm_pkg::SHIFT_DOWN) |=> count_ff == $past(count_ff) - CW'(1))
      else $error("delete did not drop the entry count by one");

   a_word_held : assert property (@(posedge clock) disable iff (reset)
      (state_ff == sclm_pkg::ST_EXEC && rsp_valid_ff && !rsp_chan.ready) |=>
         state_ff == sclm_pkg::ST_EXEC)
      else $error("execute step left while response register occupied");

endmodule

// ----- rtl/sclm_cell.sv -----
// One table slot: holds an entry, compares it with the probe, shifts with its neighbours.
module sclm_cell #(
   parameter int KEY_WIDTH     = sclm_pkg::KEY_WIDTH_DEF,
   parameter int PAYLOAD_WIDTH = sclm_pkg::PAYLOAD_WIDTH_DEF,
   parameter int INDEX_WIDTH   = 4,
   parameter int COUNT_WIDTH   = 5,
   parameter int INDEX         = 0
) (
   input  logic                                   clock,
   input  sclm_pkg::cell_ctrl_type                ctrl,
   input  logic [INDEX_WIDTH-1:0]                 target,
   input  logic [COUNT_WIDTH-1:0]                 count,
   input  logic [4*KEY_WIDTH+PAYLOAD_WIDTH-1:0]   new_entry,
   input  logic [4*KEY_WIDTH+PAYLOAD_WIDTH-1:0]   left_entry,
   input  logic [4*KEY_WIDTH+PAYLOAD_WIDTH-1:0]   right_entry,
   output logic [4*KEY_WIDTH+PAYLOAD_WIDTH-1:0]   entry,
   output logic                                   flag
);

   localparam int MW = 2 * KEY_WIDTH;
   localparam int EW = 4 * KEY_WIDTH + PAYLOAD_WIDTH;
   localparam int PW = PAYLOAD_WIDTH;
   localparam int KW = KEY_WIDTH;

   logic [EW-1:0] entry_ff, entry_in;
   logic          flag_ff, flag_in;
   logic          live;
   logic [MW-1:0] own_mag, probe_mag;
   logic          key_eq;

   assign own_mag   = entry_ff[EW-1 -: MW];
   assign probe_mag = new_entry[EW-1 -: MW];
   assign key_eq    = entry_ff[PW+2*KW-1:PW] == new_entry[PW+2*KW-1:PW];
   assign live      = COUNT_WIDTH'(INDEX) < count;

   always_comb begin
      case (ctrl.flag_sel)
         sclm_pkg::FLAG_GE: flag_in = live && (own_mag >= probe_mag);
         sclm_pkg::FLAG_GT: flag_in = live && (own_mag > probe_mag);
         sclm_pkg::FLAG_EQ: flag_in = live && key_eq;
         default:           flag_in = 1'b0;
      endcase
   end

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.shift)
         sclm_pkg::SHIFT_UP: begin
            if (INDEX_WIDTH'(INDEX) > target) begin
               entry_in = left_entry;
            end else if (INDEX_WIDTH'(INDEX) == target) begin
               entry_in = new_entry;
            end
         end
         sclm_pkg::SHIFT_DOWN: begin
            if (INDEX_WIDTH'(INDEX) >= target) begin
               entry_in = right_entry;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      flag_ff  <= flag_in;
   end

   assign entry = entry_ff;
   assign flag  = flag_ff;

endmodule

// ----- rtl/sclm_find_first.sv -----
// Tree that finds the lowest set flag along the cell row.
module sclm_find_first #(
   parameter int WIDTH       = sclm_pkg::DEPTH_DEF,
   parameter int INDEX_WIDTH = 4
) (
   input  logic [WIDTH-1:0]       flags,
   output logic                   found,
   output logic [INDEX_WIDTH-1:0] first
);

   localparam int LEVELS = $clog2(WIDTH);
   localparam int LEAVES = 1 << LEVELS;
   localparam int NODES  = 2 * LEAVES - 1;

   logic                   node_valid [NODES];
   logic [INDEX_WIDTH-1:0] node_idx   [NODES];

   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < WIDTH) begin : g_real
         assign node_valid[LEAVES-1+i] = flags[i];
      end else begin : g_pad
         assign node_valid[LEAVES-1+i] = 1'b0;
      end
      assign node_idx[LEAVES-1+i] = INDEX_WIDTH'(i);
   end

   for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
      assign node_valid[n] = node_valid[2*n+1] | node_valid[2*n+2];
      assign node_idx[n]   = node_valid[2*n+1] ? node_idx[2*n+1] : node_idx[2*n+2];
   end

   assign found = node_valid[0];
   assign first = node_idx[0];

endmodule

// ----- sim/sorted_complex_magnitude_list_test.sv -----
// Self-checking testbench for the sorted complex magnitude table.
`timescale 1ns / 1ps

module sorted_complex_magnitude_list_test;

   localparam int TABLE_DEPTH = sclm_pkg::DEPTH_DEF;
   localparam int KW          = sclm_pkg::KEY_WIDTH_DEF;
   localparam int PW          = sclm_pkg::PAYLOAD_WIDTH_DEF;
   localparam logic [sclm_pkg::MODE_W-1:0] MODE_UNDEF_LO = 3'd5;
   localparam logic [sclm_pkg::MODE_W-1:0] MODE_UNDEF_HI = 3'd7;

   typedef struct {
      sclm_pkg::status_type                   status;
      logic [sclm_pkg::OUT_IDX_W-1:0]         index;
      logic signed [sclm_pkg::OUT_KEY_W-1:0]  re;
      logic signed [sclm_pkg::OUT_KEY_W-1:0]  im;
      logic [sclm_pkg::OUT_PAY_W-1:0]         pay;
      logic                                   hit;
      logic [sclm_pkg::OUT_IDX_W-1:0]         count;
   } table_result_type;

   logic clock;
   logic reset;

   sclm_req_if req_chan ();
   sclm_rsp_if rsp_chan ();

   sorted_complex_magnitude_list i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the table
   logic signed [KW-1:0]     table_re  [TABLE_DEPTH];
   logic signed [KW-1:0]     table_im  [TABLE_DEPTH];
   logic [PW-1:0]            table_pay [TABLE_DEPTH];
   int                       table_count;

   table_result_type pending_results [$];

   int send_idle_pct;
   int recv_idle_pct;
   int fault_count;
   int fill_target;
   int words_sent;
   int words_checked;
   int mode_seen [8];
   int full_seen;
   int miss_seen;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint sq_mag(logic signed [KW-1:0] re,
                                     logic signed [KW-1:0] im);
      return longint'(re) * longint'(re) + longint'(im) * longint'(im);
   endfunction

   // applies one operation to the shadow table and returns the word it should produce
   task automatic apply_table_op(input logic [sclm_pkg::MODE_W-1:0] mode,
                                 input logic signed [KW-1:0] re,
                                 input logic signed [KW-1:0] im,
                                 input logic [PW-1:0] pay,
                                 input logic [sclm_pkg::POS_W-1:0] pos,
                                 output table_result_type r);
      longint probe;
      int     i;
      int     lo;
      int     hi;
      int     mid;
      probe = sq_mag(re, im);
      r.status = sclm_pkg::STATUS_MISS;
      r.index  = '0;
      r.re     = '0;
      r.im     = '0;
      r.pay    = '0;
      r.hit    = 1'b0;
      case (mode)
         sclm_pkg::MODE_INSERT: begin
            if (table_count >= TABLE_DEPTH) begin
               r.status = sclm_pkg::STATUS_FULL;
            end else begin
               i = 0;
               while (i < table_count && probe > sq_mag(table_re[i], table_im[i])) i++;
               for (int j = table_count; j > i; j--) begin
                  table_re[j]  = table_re[j-1];
                  table_im[j]  = table_im[j-1];
                  table_pay[j] = table_pay[j-1];
               end
               table_re[i]  = re;
               table_im[i]  = im;
               table_pay[i] = pay;
               table_count++;
               r.status = sclm_pkg::STATUS_DONE;
               r.index  = sclm_pkg::OUT_IDX_W'(i);
               r.re     = re;
               r.im     = im;
               r.pay    = pay;
            end
         end
         sclm_pkg::MODE_SEARCH: begin
            for (i = 0; i < table_count; i++) begin
               if (table_re[i] == re && table_im[i] == im) break;
            end
            if (i < table_count) begin
               r.status = sclm_pkg::STATUS_DONE;
               r.index  = sclm_pkg::OUT_IDX_W'(i);
               r.re     = table_re[i];
               r.im     = table_im[i];
               r.pay    = table_pay[i];
            end
         end
         sclm_pkg::MODE_LOCATE: begin
            if (pos < table_count) begin
               lo = pos;
               hi = table_count;
               while (hi - lo > 1) begin
                  mid = (lo + hi) / 2;
                  if (probe >= sq_mag(table_re[mid], table_im[mid])) lo = mid;
                  else hi = mid;
               end
               r.status = sclm_pkg::STATUS_DONE;
               r.index  = sclm_pkg::OUT_IDX_W'(lo);
               r.re     = table_re[lo];
               r.im     = table_im[lo];
               r.pay    = table_pay[lo];
               r.hit    = (sq_mag(table_re[lo], table_im[lo]) <= probe);
            end
         end
         sclm_pkg::MODE_READ: begin
            if (pos < table_count) begin
               r.status = sclm_pkg::STATUS_DONE;
               r.index  = sclm_pkg::OUT_IDX_W'(pos);
               r.re     = table_re[pos];
               r.im     = table_im[pos];
               r.pay    = table_pay[pos];
            end
         end
         sclm_pkg::MODE_DELETE: begin
            if (pos < table_count) begin
               r.status = sclm_pkg::STATUS_DONE;
               r.index  = sclm_pkg::OUT_IDX_W'(pos);
               r.re     = table_re[pos];
               r.im     = table_im[pos];
               r.pay    = table_pay[pos];
               for (int j = pos; j < table_count - 1; j++) begin
                  table_re[j]  = table_re[j+1];
                  table_im[j]  = table_im[j+1];
                  table_pay[j] = table_pay[j+1];
               end
               table_count--;
            end
         end
         default: ;
      endcase
      r.count = sclm_pkg::OUT_IDX_W'(table_count);
   endtask

   task automatic send_request(input logic [sclm_pkg::MODE_W-1:0] mode,
                               input logic signed [KW-1:0] re,
                               input logic signed [KW-1:0] im,
                               input logic [PW-1:0] pay,
                               input logic [sclm_pkg::POS_W-1:0] pos);
      table_result_type r;
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.mode     <= mode;
      req_chan.key_real <= re;
      req_chan.key_imag <= im;
      req_chan.payload  <= pay;
      req_chan.position <= pos;
      do @(posedge clock); while (!req_chan.ready);
      apply_table_op(mode, re, im, pay, pos, r);
      pending_results.push_back(r);
      words_sent++;
      mode_seen[mode]++;
      if (r.status == sclm_pkg::STATUS_FULL) full_seen++;
      if (r.status == sclm_pkg::STATUS_MISS) miss_seen++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      table_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_results.size() == 0) begin
               $error("response word with no request outstanding");
               fault_count++;
            end else begin
               want = pending_results.pop_front();
               compare_field("status", want.status, rsp_chan.status);
               compare_field("out_index", want.index, rsp_chan.out_index);
               compare_field("out_real", want.re, rsp_chan.out_real);
               compare_field("out_imag", want.im, rsp_chan.out_imag);
               compare_field("out_payload", want.pay, rsp_chan.out_payload);
               compare_field("hit", want.hit, rsp_chan.hit);
               compare_field("out_count", want.count, rsp_chan.out_count);
               words_checked++;
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic signed [KW-1:0] pick_coord(int kind);
      case (kind)
         0: return KW'($urandom);
         1: return KW'($signed($urandom_range(12)) - 6);
         default: begin
            case ($urandom_range(3))
               0: return 16'sh8000;
               1: return 16'sh7fff;
               2: return 16'sh0000;
               default: return 16'shffff;
            endcase
         end
      endcase
   endfunction

   task automatic test_directed();
      send_request(sclm_pkg::MODE_READ,   0, 0, 0, 0);
      send_request(sclm_pkg::MODE_DELETE, 0, 0, 0, 0);
      send_request(sclm_pkg::MODE_LOCATE, 0, 0, 0, 0);
      send_request(sclm_pkg::MODE_SEARCH, 0, 0, 0, 0);
      send_request(MODE_UNDEF_HI, 1, 1, 32'hffff_ffff, 4'd15);
      send_request(sclm_pkg::MODE_INSERT, 3, 4, 32'd1, 0);
      send_request(sclm_pkg::MODE_INSERT, 4, 3, 32'd2, 0);
      send_request(sclm_pkg::MODE_INSERT, -5, 0, 32'd3, 0);
      send_request(sclm_pkg::MODE_INSERT, 16'sh8000, 16'sh8000, 32'hffff_ffff, 0);
      send_request(sclm_pkg::MODE_INSERT, 16'sh7fff, 16'sh7fff, 32'h5555_aaaa, 0);
      send_request(sclm_pkg::MODE_INSERT, 0, 0, 32'd0, 0);
      send_request(sclm_pkg::MODE_SEARCH, 4, 3, 0, 0);
      send_request(sclm_pkg::MODE_SEARCH, 3, -4, 0, 0);
      send_request(sclm_pkg::MODE_LOCATE, 0, 0, 0, 0);
      send_request(sclm_pkg::MODE_LOCATE, 1, 1, 0, 4'd1);
      send_request(sclm_pkg::MODE_LOCATE, 16'sh8000, 16'sh8000, 0, 0);
      send_request(sclm_pkg::MODE_LOCATE, 3, 4, 0, 4'd5);
      send_request(sclm_pkg::MODE_LOCATE, 3, 4, 0, 4'd15);
      send_request(sclm_pkg::MODE_READ,   0, 0, 0, 4'd15);
      send_request(sclm_pkg::MODE_READ,   0, 0, 0, 4'd5);
      send_request(sclm_pkg::MODE_DELETE, 0, 0, 0, 4'd2);
      send_request(sclm_pkg::MODE_DELETE, 0, 0, 0, 4'd0);
      send_request(MODE_UNDEF_LO, 0, 0, 0, 0);
      send_request(sclm_pkg::MODE_READ,   0, 0, 0, 4'd0);
   endtask

   task automatic test_full_table();
      while (table_count < TABLE_DEPTH)
         send_request(sclm_pkg::MODE_INSERT, pick_coord($urandom_range(2)),
                      pick_coord($urandom_range(2)), $urandom, 0);
      repeat (3)
         send_request(sclm_pkg::MODE_INSERT, pick_coord(0), pick_coord(0), $urandom, 0);
      send_request(sclm_pkg::MODE_READ,   0, 0, 0, 4'd15);
      send_request(sclm_pkg::MODE_LOCATE, pick_coord(0), pick_coord(0), 0, 4'd0);
      send_request(sclm_pkg::MODE_DELETE, 0, 0, 0, 4'd15);
      send_request(sclm_pkg::MODE_DELETE, 0, 0, 0, 4'd0);
      while (table_count > 0)
         send_request(sclm_pkg::MODE_DELETE, 0, 0, 0,
                      sclm_pkg::POS_W'($urandom_range(table_count - 1)));
   endtask

   task automatic test_random(input int n);
      int                               r;
      int                               kind;
      int                               ins_w;
      int                               idx;
      logic [sclm_pkg::MODE_W-1:0]      m;
      logic signed [KW-1:0]             re;
      logic signed [KW-1:0]             im;
      logic [sclm_pkg::POS_W-1:0]       pos;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) fill_target = $urandom_range(TABLE_DEPTH);
         ins_w = (table_count < fill_target) ? 50 : 12;
         if ($urandom_range(99) < ins_w) begin
            m = sclm_pkg::MODE_INSERT;
         end else begin
            r = $urandom_range(99);
            if (r < 25) m = sclm_pkg::MODE_SEARCH;
            else if (r < 50) m = sclm_pkg::MODE_LOCATE;
            else if (r < 70) m = sclm_pkg::MODE_READ;
            else if (r < 95) m = sclm_pkg::MODE_DELETE;
            else m = sclm_pkg::MODE_W'($urandom_range(MODE_UNDEF_HI, MODE_UNDEF_LO));
         end
         kind = $urandom_range(9);
         if (kind >= 7 && table_count > 0) begin
            idx = $urandom_range(table_count - 1);
            re  = table_re[idx];
            im  = table_im[idx];
         end else begin
            kind = (kind < 3) ? 0 : (kind < 6) ? 1 : 2;
            re   = pick_coord(kind);
            im   = pick_coord(kind);
         end
         if (table_count > 0 && $urandom_range(3) != 0)
            pos = sclm_pkg::POS_W'($urandom_range(table_count - 1));
         else pos = sclm_pkg::POS_W'($urandom_range(15));
         send_request(m, re, im, $urandom, pos);
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.mode     = sclm_pkg::MODE_INSERT;
      req_chan.key_real = '0;
      req_chan.key_imag = '0;
      req_chan.payload  = '0;
      req_chan.position = '0;
      rsp_chan.ready    = 1'b0;
      table_count       = 0;
      fault_count       = 0;
      fill_target       = 0;
      words_sent        = 0;
      words_checked     = 0;
      full_seen         = 0;
      miss_seen         = 0;
      foreach (mode_seen[k]) mode_seen[k] = 0;
      send_idle_pct     = 34;
      recv_idle_pct     = 73;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_table();
      test_random(220);
      send_idle_pct = 73;
      recv_idle_pct = 34;
      test_random(220);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(220);

      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d request words sent, %0d responses checked; inserts %0d, searches %0d,",
               words_sent, words_checked, mode_seen[sclm_pkg::MODE_INSERT],
               mode_seen[sclm_pkg::MODE_SEARCH]);
      $display("locates %0d, reads %0d, deletes %0d, full rejections %0d, misses %0d",
               mode_seen[sclm_pkg::MODE_LOCATE], mode_seen[sclm_pkg::MODE_READ],
               mode_seen[sclm_pkg::MODE_DELETE], full_seen, miss_seen);
      if (fault_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d responses outstanding", pending_results.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
